// ===== rtl/gfl_pkg.sv =====
`default_nettype none
package gfl_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ORIGIN_LAT  = 3'd0,
    REG_ORIGIN_LON  = 3'd1,
    REG_NORTH_SCALE = 3'd2,
    REG_EAST_SCALE  = 3'd3,
    REG_YAW_COS     = 3'd4,
    REG_YAW_SIN     = 3'd5,
    REG_YAW_ANGLE   = 3'd6,
    REG_CONVENTION  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CONV_NORTH_CW  = 2'd0,
    CONV_NORTH_CCW = 2'd1,
    CONV_EAST_CCW  = 2'd2
  } conv_t;

  typedef struct packed {
    logic               pose_valid;
    logic signed [31:0] map_x_mm;
    logic signed [31:0] map_y_mm;
    logic signed [15:0] map_heading;
    logic signed [15:0] heading_quat_z;
    logic signed [15:0] heading_quat_w;
  } pose_t;

  // Arctangent of 2^-i as a 32-bit binary angle, truncated.
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933405;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335086;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41721;
      15: r = 32'd20860;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2607;
      19: r = 32'd1303;
      20: r = 32'd651;
      21: r = 32'd325;
      22: r = 32'd162;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gfl_if.sv =====
`default_nettype none
interface gfl_fix_if;
  logic               valid;
  logic               ready;
  logic signed [2:0]  fix_status;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, fix_status, latitude, longitude, quat_x, quat_y, quat_z,
                  quat_w, input ready);
  modport sink (input valid, fix_status, latitude, longitude, quat_x, quat_y, quat_z,
                quat_w, output ready);
endinterface

interface gfl_pose_if;
  logic               valid;
  logic               ready;
  logic               pose_valid;
  logic signed [31:0] map_x_mm;
  logic signed [31:0] map_y_mm;
  logic signed [15:0] map_heading;
  logic signed [15:0] heading_quat_z;
  logic signed [15:0] heading_quat_w;
  modport source (output valid, pose_valid, map_x_mm, map_y_mm, map_heading,
                  heading_quat_z, heading_quat_w, input ready);
  modport sink (input valid, pose_valid, map_x_mm, map_y_mm, map_heading,
                heading_quat_z, heading_quat_w, output ready);
endinterface
`default_nettype wire

// ===== rtl/gfl_cordic_vec.sv =====
`default_nettype none
module gfl_cordic_vec #(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] s_in,
  input  wire logic signed [33:0] c_in,
  output logic        [31:0]      angle
);
  import gfl_pkg::*;

  logic signed [35:0] xs [0:STAGES];
  logic signed [35:0] ys [0:STAGES];
  logic        [31:0] zs [0:STAGES];
  logic               zf [0:STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (s_in == 34'sd0) && (c_in == 34'sd0);
      if (c_in < 0) begin
        xs[0] <= -36'(c_in);
        ys[0] <= -36'(s_in);
        zs[0] <= 32'h8000_0000;
      end else begin
        xs[0] <= 36'(c_in);
        ys[0] <= 36'(s_in);
        zs[0] <= 32'd0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end
      end
    end
  end

  assign angle = zf[STAGES] ? 32'd0 : zs[STAGES];

endmodule
`default_nettype wire

// ===== rtl/gfl_cordic_rot.sv =====
`default_nettype none
module gfl_cordic_rot #(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] hq_in,
  output logic signed [15:0]      hq_out,
  output logic signed [15:0]      sin_out,
  output logic signed [15:0]      cos_out
);
  import gfl_pkg::*;

  localparam logic signed [32:0] X_INIT = 33'sd652032874;

  logic signed [32:0] xs [0:STAGES];
  logic signed [32:0] ys [0:STAGES];
  logic signed [33:0] zs [0:STAGES];
  logic signed [15:0] hs [0:STAGES];
  logic signed [32:0] y_rnd;
  logic signed [32:0] x_rnd;
  logic signed [17:0] y_sh;
  logic signed [17:0] x_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= X_INIT;
      ys[0] <= 33'sd0;
      zs[0] <= {{3{hq_in[15]}}, hq_in, 15'd0};
      hs[0] <= hq_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        hs[i+1] <= hs[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - $signed({2'b00, atan_entry(i)});
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + $signed({2'b00, atan_entry(i)});
        end
      end
    end
  end

  always_comb begin
    y_rnd = ys[STAGES] + 33'sd16384;
    x_rnd = xs[STAGES] + 33'sd16384;
    y_sh  = y_rnd[32:15];
    x_sh  = x_rnd[32:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hq_out <= hs[STAGES];
      if (y_sh > 18'sd32767) sin_out <= 16'sh7fff;
      else if (y_sh < -18'sd32768) sin_out <= 16'sh8000;
      else sin_out <= y_sh[15:0];
      if (x_sh > 18'sd32767) cos_out <= 16'sh7fff;
      else if (x_sh < -18'sd32768) cos_out <= 16'sh8000;
      else cos_out <= x_sh[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/geodetic_fix_to_local_map_pose.sv =====
// Converts a satellite fix and an orientation quaternion into a local map pose.
// Requests arrive on the fix channel and results leave on the pose channel, both
// valid/ready; a request is taken when valid and ready are high at a clock edge.
// Every request gives exactly one result, in order. A fix with a negative status
// gives a result whose fields are all zero.
// The datapath is a single pipeline: a fix can be taken every cycle while the
// skid register is empty. The depth is set by the two CORDIC chains for the
// heading, one stage per iteration; the position multiplies run alongside and
// are delayed to match. If the receiver holds ready low, one result is parked
// in a skid register and the pipeline freezes until it drains; nothing is lost
// or repeated. Registers must be written over the APB port only while the block
// is idle; the block itself does not enforce this.
// Synchronous reset empties the pipeline and loads the register defaults:
// origin zero, scales zero, map yaw zero, heading already east counterclockwise.
`default_nettype none
module geodetic_fix_to_local_map_pose #(
  parameter int CORDIC_STAGES = gfl_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  gfl_fix_if.sink                        fix,
  gfl_pose_if.source                     pose,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [gfl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import gfl_pkg::*;

  localparam int LAT = 2 * CORDIC_STAGES + 6;
  localparam int DLY = 2 * CORDIC_STAGES + 1;

  logic signed [30:0] origin_latitude;
  logic signed [31:0] origin_longitude;
  logic        [19:0] north_scale;
  logic        [19:0] east_scale;
  logic signed [15:0] map_yaw_cos;
  logic signed [15:0] map_yaw_sin;
  logic signed [15:0] map_yaw_angle;
  logic        [1:0]  heading_convention;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_latitude    <= '0;
      origin_longitude   <= '0;
      north_scale        <= '0;
      east_scale         <= '0;
      map_yaw_cos        <= 16'sd32767;
      map_yaw_sin        <= '0;
      map_yaw_angle      <= '0;
      heading_convention <= CONV_EAST_CCW;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_ORIGIN_LAT:  origin_latitude    <= pwdata[30:0];
        REG_ORIGIN_LON:  origin_longitude   <= pwdata;
        REG_NORTH_SCALE: north_scale        <= pwdata[19:0];
        REG_EAST_SCALE:  east_scale         <= pwdata[19:0];
        REG_YAW_COS:     map_yaw_cos        <= pwdata[15:0];
        REG_YAW_SIN:     map_yaw_sin        <= pwdata[15:0];
        REG_YAW_ANGLE:   map_yaw_angle      <= pwdata[15:0];
        REG_CONVENTION:  heading_convention <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ORIGIN_LAT:  prdata = {1'b0, origin_latitude};
      REG_ORIGIN_LON:  prdata = origin_longitude;
      REG_NORTH_SCALE: prdata = {12'd0, north_scale};
      REG_EAST_SCALE:  prdata = {12'd0, east_scale};
      REG_YAW_COS:     prdata = {16'd0, map_yaw_cos};
      REG_YAW_SIN:     prdata = {16'd0, map_yaw_sin};
      REG_YAW_ANGLE:   prdata = {16'd0, map_yaw_angle};
      REG_CONVENTION:  prdata = {30'd0, heading_convention};
      default:         prdata = '0;
    endcase
  end

  logic en;
  logic skid_valid;
  pose_t skid;
  pose_t last;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] nofix;

  assign fix.ready = en;
  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], fix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nofix <= {nofix[LAT-2:0], fix.fix_status[2]};
    end
  end

  // Position path.
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic signed [31:0] qwz, qxy, qyy, qzz;
  logic signed [53:0] nprod;
  logic signed [54:0] eprod;
  logic signed [33:0] s_q, c_q;
  logic signed [53:0] nrnd;
  logic signed [54:0] ernd;
  logic signed [45:0] north;
  logic signed [46:0] east;
  logic signed [62:0] m_ce, m_sn, m_cn, m_se;
  logic signed [63:0] sx, sy;
  logic signed [40:0] tx, ty;
  logic signed [31:0] px, py;
  logic signed [31:0] pxd [0:DLY-1];
  logic signed [31:0] pyd [0:DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dlat <= 32'(fix.latitude) - 32'(origin_latitude);
      dlon <= 33'(fix.longitude) - 33'(origin_longitude);
      qwz  <= fix.quat_w * fix.quat_z;
      qxy  <= fix.quat_x * fix.quat_y;
      qyy  <= fix.quat_y * fix.quat_y;
      qzz  <= fix.quat_z * fix.quat_z;
      nprod <= 54'(dlat * $signed({1'b0, north_scale}));
      eprod <= 55'(dlon * $signed({1'b0, east_scale}));
      s_q   <= (34'(qwz) + 34'(qxy)) <<< 1;
      c_q   <= 34'sd1073741824 - ((34'(qyy) + 34'(qzz)) <<< 1);
      north <= nrnd[53:8];
      east  <= ernd[54:8];
      m_ce  <= 63'(map_yaw_cos * east);
      m_sn  <= 63'(map_yaw_sin * north);
      m_cn  <= 63'(map_yaw_cos * north);
      m_se  <= 63'(map_yaw_sin * east);
      px    <= (tx > 41'sd2147483647) ? 32'sh7fffffff :
               (tx < -41'sd2147483648) ? 32'sh80000000 : tx[31:0];
      py    <= (ty > 41'sd2147483647) ? 32'sh7fffffff :
               (ty < -41'sd2147483648) ? 32'sh80000000 : ty[31:0];
      pxd[0] <= px;
      pyd[0] <= py;
    end
  end

  always_comb begin
    nrnd = nprod + 54'sd128;
    ernd = eprod + 55'sd128;
    sx   = 64'(m_ce) + 64'(m_sn) + 64'sd4194304;
    sy   = 64'(m_cn) - 64'(m_se) + 64'sd4194304;
    tx   = sx[63:23];
    ty   = sy[63:23];
  end

  for (genvar k = 1; k < DLY; k++) begin : g_pdly
    always_ff @(posedge clk) begin
      if (en) begin
        pxd[k] <= pxd[k-1];
        pyd[k] <= pyd[k-1];
      end
    end
  end

  // Heading path.
  logic [31:0] raw;
  logic [31:0] enu;
  logic [31:0] map_ang;
  logic [31:0] map_rnd;
  logic signed [15:0] hq;
  logic signed [15:0] hq_o, qz_o, qw_o;

  gfl_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk   (clk),
    .en    (en),
    .s_in  (s_q),
    .c_in  (c_q),
    .angle (raw)
  );

  always_comb begin
    case (heading_convention)
      CONV_NORTH_CW:  enu = 32'h4000_0000 - raw;
      CONV_NORTH_CCW: enu = 32'h4000_0000 + raw;
      default:        enu = raw;
    endcase
    map_ang = enu - {map_yaw_angle, 16'd0};
    map_rnd = map_ang + 32'h0000_8000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hq <= map_rnd[31:16];
    end
  end

  gfl_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk     (clk),
    .en      (en),
    .hq_in   (hq),
    .hq_out  (hq_o),
    .sin_out (qz_o),
    .cos_out (qw_o)
  );

  // Output stage and skid register.
  always_comb begin
    if (nofix[LAT-1]) begin
      last = '0;
    end else begin
      last.pose_valid     = 1'b1;
      last.map_x_mm       = pxd[DLY-1];
      last.map_y_mm       = pyd[DLY-1];
      last.map_heading    = hq_o;
      last.heading_quat_z = qz_o;
      last.heading_quat_w = qw_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pose.ready) skid_valid <= 1'b0;
    end else if (vld[LAT-1] && !pose.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skid <= last;
    end
  end

  assign pose.valid          = skid_valid || vld[LAT-1];
  assign pose.pose_valid     = skid_valid ? skid.pose_valid     : last.pose_valid;
  assign pose.map_x_mm       = skid_valid ? skid.map_x_mm       : last.map_x_mm;
  assign pose.map_y_mm       = skid_valid ? skid.map_y_mm       : last.map_y_mm;
  assign pose.map_heading    = skid_valid ? skid.map_heading    : last.map_heading;
  assign pose.heading_quat_z = skid_valid ? skid.heading_quat_z : last.heading_quat_z;
  assign pose.heading_quat_w = skid_valid ? skid.heading_quat_w : last.heading_quat_w;

endmodule
`default_nettype wire
